@@ hdl/bpl_pkg.sv @@
package bpl_pkg;

	localparam int OP_W     = 3;
	localparam int VAL_W    = 32;
	localparam int IDX_W    = 5;
	localparam int ST_W     = 2;
	localparam int CNT_W    = 5;
	localparam int DEPTH_DEF = 16;

	localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
	localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
	localparam logic [OP_W-1:0] OP_INSERT     = 3'd2;
	localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd3;
	localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd4;
	localparam logic [OP_W-1:0] OP_DELETE     = 3'd5;
	localparam logic [OP_W-1:0] OP_DUMP       = 3'd6;

	localparam logic [ST_W-1:0] ST_OK     = 2'd0;
	localparam logic [ST_W-1:0] ST_FULL   = 2'd1;
	localparam logic [ST_W-1:0] ST_EMPTY  = 2'd2;
	localparam logic [ST_W-1:0] ST_BADIDX = 2'd3;

	typedef struct packed {
		logic [ST_W-1:0]         status;
		logic signed [VAL_W-1:0] elem_value;
		logic [CNT_W-1:0]        count_now;
		logic                    last;
	} res_t;

endpackage

@@ hdl/bpl_in_if.sv @@
interface bpl_in_if;
	import bpl_pkg::*;

	logic                    valid;
	logic                    ready;
	logic [OP_W-1:0]         op;
	logic signed [VAL_W-1:0] value;
	logic [IDX_W-1:0]        index;

	modport source (output valid, output op, output value, output index, input ready);
	modport sink (input valid, input op, input value, input index, output ready);

endinterface

@@ hdl/bpl_out_if.sv @@
interface bpl_out_if;
	import bpl_pkg::*;

	logic                    valid;
	logic                    ready;
	logic [ST_W-1:0]         status;
	logic signed [VAL_W-1:0] elem_value;
	logic [CNT_W-1:0]        count_now;
	logic                    last;

	modport source (output valid, output status, output elem_value, output count_now,
		output last, input ready);
	modport sink (input valid, input status, input elem_value, input count_now,
		input last, output ready);

endinterface

@@ hdl/bounded_positional_list_unit.sv @@
// Ordered list of up to DEPTH signed 32-bit values held in a single-port-write,
// single-port-read element memory with a registered read port. One operation
// is taken per request transaction and the unit works on one at a time. A refused
// operation (full, empty, bad index), a no-op or a dump of an empty list goes
// from S_EXEC to S_RESP, which loads its result into the output register once
// the output stage is free. A push back or pop back moves no entry and a push
// front, insert or delete shifts entries, the shift walking the memory one entry
// a cycle in S_INS or S_DEL; all of these then end in S_RESP. A dump issues one
// memory read a cycle and delivers one element per cycle while the response
// side is ready. A new request is taken as soon as the previous operation has
// handed its last result to the output register, even while that result is
// still waiting to be taken.
module bounded_positional_list_unit #(
	parameter int DEPTH = bpl_pkg::DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	bpl_in_if.sink    req,
	bpl_out_if.source rsp
);
	import bpl_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic                    mem_we, mem_re;
	logic [AW-1:0]           mem_waddr, mem_raddr;
	logic signed [VAL_W-1:0] mem_wdata, mem_rdata;
	logic                    res_ready, res_load;
	res_t                    res, res_q;
	logic                    out_v_q;

	bpl_mem #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	bpl_seq #(
		.DEPTH (DEPTH),
		.AW    (AW),
		.CW    (CW)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata),
		.res_ready (res_ready),
		.res_load  (res_load),
		.res       (res)
	);

	// output stage frees up in the same cycle its transaction completes
	assign res_ready = !out_v_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else begin
			out_v_q <= res_load || (out_v_q && !rsp.ready);
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q <= res;
		end
	end

	assign rsp.valid      = out_v_q;
	assign rsp.status     = res_q.status;
	assign rsp.elem_value = res_q.elem_value;
	assign rsp.count_now  = res_q.count_now;
	assign rsp.last       = res_q.last;

endmodule

@@ hdl/bpl_mem.sv @@
module bpl_mem #(
	parameter int DEPTH = bpl_pkg::DEPTH_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic [AW-1:0]                    waddr,
	input  logic signed [bpl_pkg::VAL_W-1:0] wdata,
	input  logic                             re,
	input  logic [AW-1:0]                    raddr,
	output logic signed [bpl_pkg::VAL_W-1:0] rdata
);
	import bpl_pkg::*;

	logic signed [VAL_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read data holds until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ hdl/bpl_seq.sv @@
module bpl_seq #(
	parameter int DEPTH = bpl_pkg::DEPTH_DEF,
	parameter int AW    = $clog2(DEPTH),
	parameter int CW    = $clog2(DEPTH + 1)
) (
	input  logic                             clk,
	input  logic                             arst_n,
	bpl_in_if.sink                           req,
	output logic                             mem_we,
	output logic [AW-1:0]                    mem_waddr,
	output logic signed [bpl_pkg::VAL_W-1:0] mem_wdata,
	output logic                             mem_re,
	output logic [AW-1:0]                    mem_raddr,
	input  logic signed [bpl_pkg::VAL_W-1:0] mem_rdata,
	input  logic                             res_ready,
	output logic                             res_load,
	output bpl_pkg::res_t                    res
);
	import bpl_pkg::*;

	localparam int XW = (CW > IDX_W) ? CW : IDX_W;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_EXEC = 3'd1;
	localparam logic [2:0] S_INS  = 3'd2;
	localparam logic [2:0] S_DEL  = 3'd3;
	localparam logic [2:0] S_DUMP = 3'd4;
	localparam logic [2:0] S_RESP = 3'd5;

	logic [2:0]              state_q, state_d;
	logic [CW-1:0]           cnt_q, cnt_d;
	logic [CW-1:0]           ptr_q, ptr_d;
	logic [CW-1:0]           pos_q, pos_d;
	logic [CW-1:0]           dptr_q, dptr_d;
	logic [ST_W-1:0]         stat_q, stat_d;
	logic                    wpend_v_q, wpend_v_d;
	logic [AW-1:0]           wpend_a_q, wpend_a_d;
	logic                    dval_q, dval_d;
	logic [OP_W-1:0]         op_q;
	logic signed [VAL_W-1:0] val_q;
	logic [IDX_W-1:0]        idx_q;

	logic [XW-1:0] cnt_x, pos_x;
	logic          full, empty;

	assign req.ready = (state_q == S_IDLE);

	assign cnt_x = XW'(cnt_q);
	assign full  = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);

	// position the operation works on
	always_comb begin
		case (op_q) inside
			OP_PUSH_BACK:         pos_x = cnt_x;
			OP_INSERT, OP_DELETE: pos_x = XW'(idx_q);
			OP_POP_BACK:          pos_x = XW'(cnt_x - 1'b1);
			default:              pos_x = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			op_q  <= req.op;
			val_q <= req.value;
			idx_q <= req.index;
		end
	end

	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		ptr_d     = ptr_q;
		pos_d     = pos_q;
		dptr_d    = dptr_q;
		stat_d    = stat_q;
		wpend_v_d = 1'b0;
		wpend_a_d = wpend_a_q;
		dval_d    = dval_q;
		mem_we    = 1'b0;
		mem_waddr = wpend_a_q;
		mem_wdata = mem_rdata;
		mem_re    = 1'b0;
		mem_raddr = '0;
		res_load  = 1'b0;
		res.status     = stat_q;
		res.elem_value = '0;
		res.count_now  = CNT_W'(cnt_q);
		res.last       = 1'b1;

		unique case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				unique case (op_q) inside
					OP_PUSH_FRONT, OP_PUSH_BACK, OP_INSERT: begin
						if (full) begin
							stat_d  = ST_FULL;
							state_d = S_RESP;
						end else if (pos_x > cnt_x) begin
							stat_d  = ST_BADIDX;
							state_d = S_RESP;
						end else begin
							ptr_d   = cnt_q;
							pos_d   = pos_x[CW-1:0];
							state_d = S_INS;
						end
					end
					OP_POP_FRONT, OP_POP_BACK, OP_DELETE: begin
						if (empty) begin
							stat_d  = ST_EMPTY;
							state_d = S_RESP;
						end else if (pos_x >= cnt_x) begin
							stat_d  = ST_BADIDX;
							state_d = S_RESP;
						end else begin
							ptr_d   = pos_x[CW-1:0];
							state_d = S_DEL;
						end
					end
					OP_DUMP: begin
						if (empty) begin
							stat_d  = ST_EMPTY;
							state_d = S_RESP;
						end else begin
							ptr_d   = '0;
							dval_d  = 1'b0;
							state_d = S_DUMP;
						end
					end
					default: begin
						stat_d  = ST_OK;
						state_d = S_RESP;
					end
				endcase
			end
			S_INS: begin
				// write back the entry read last cycle, one place further back
				if (wpend_v_q) begin
					mem_we = 1'b1;
				end
				if (ptr_q > pos_q) begin
					mem_re    = 1'b1;
					mem_raddr = AW'(ptr_q - 1'b1);
					wpend_v_d = 1'b1;
					wpend_a_d = ptr_q[AW-1:0];
					ptr_d     = CW'(ptr_q - 1'b1);
				end else if (!wpend_v_q) begin
					mem_we    = 1'b1;
					mem_waddr = pos_q[AW-1:0];
					mem_wdata = val_q;
					cnt_d     = CW'(cnt_q + 1'b1);
					stat_d    = ST_OK;
					state_d   = S_RESP;
				end
			end
			S_DEL: begin
				// write back the entry read last cycle, one place further forward
				if (wpend_v_q) begin
					mem_we = 1'b1;
				end
				if (CW'(ptr_q + 1'b1) < cnt_q) begin
					mem_re    = 1'b1;
					mem_raddr = AW'(ptr_q + 1'b1);
					wpend_v_d = 1'b1;
					wpend_a_d = ptr_q[AW-1:0];
					ptr_d     = CW'(ptr_q + 1'b1);
				end else if (!wpend_v_q) begin
					cnt_d   = CW'(cnt_q - 1'b1);
					stat_d  = ST_OK;
					state_d = S_RESP;
				end
			end
			S_DUMP: begin
				if (dval_q && res_ready) begin
					res_load       = 1'b1;
					res.status     = ST_OK;
					res.elem_value = mem_rdata;
					res.last       = (dptr_q == CW'(cnt_q - 1'b1));
					dval_d         = 1'b0;
				end
				if (!dval_q || res_ready) begin
					if (ptr_q < cnt_q) begin
						mem_re    = 1'b1;
						mem_raddr = ptr_q[AW-1:0];
						dval_d    = 1'b1;
						dptr_d    = ptr_q;
						ptr_d     = CW'(ptr_q + 1'b1);
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			S_RESP: begin
				if (res_ready) begin
					res_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= '0;
			wpend_v_q <= 1'b0;
			dval_q    <= 1'b0;
		end else begin
			state_q   <= state_d;
			cnt_q     <= cnt_d;
			wpend_v_q <= wpend_v_d;
			dval_q    <= dval_d;
		end
	end

	always_ff @(posedge clk) begin
		ptr_q     <= ptr_d;
		pos_q     <= pos_d;
		dptr_q    <= dptr_d;
		stat_q    <= stat_d;
		wpend_a_q <= wpend_a_d;
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("element count above depth");

	a_cnt_change: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q != $past(cnt_q)) |-> (state_q == S_RESP))
		else $error("count changed outside a status result");

	a_load_ready: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |-> res_ready)
		else $error("result loaded into a full output stage");

	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> (state_q == S_EXEC))
		else $error("accepted transaction not decoded");

endmodule

@@ test/bpl_checker.sv @@
`timescale 1ns / 100ps

module bpl_checker #(
	parameter int DEPTH = bpl_pkg::DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	bpl_in_if    req,
	bpl_out_if   rsp,
	output int   fail_count,
	output int   pending
);
	import bpl_pkg::*;

	localparam int MAX_PRINTS = 40;

	logic signed [VAL_W-1:0] list_vals [DEPTH];
	int                      list_len;
	res_t                    expected_results [$];
	int                      result_no;

	initial begin
		fail_count = 0;
		pending    = 0;
		list_len   = 0;
		result_no  = 0;
	end

	task automatic report(input string what, input longint got, input longint want);
		if (fail_count < MAX_PRINTS) begin
			$display("%t checker: result %0d %s: got %0d, expected %0d",
				$time, result_no, what, got, want);
		end
		fail_count++;
	endtask

	task automatic push_result(input logic [ST_W-1:0] st, input logic signed [VAL_W-1:0] v,
		input logic is_last);
		res_t r;
		r.status     = st;
		r.elem_value = v;
		r.count_now  = CNT_W'(list_len);
		r.last       = is_last;
		expected_results.push_back(r);
	endtask

	function automatic logic [ST_W-1:0] insert_at(input int pos, input logic signed [VAL_W-1:0] v);
		if (list_len >= DEPTH)
			return ST_FULL;
		if (pos > list_len)
			return ST_BADIDX;
		for (int i = list_len; i > pos; i--)
			list_vals[i] = list_vals[i-1];
		list_vals[pos] = v;
		list_len++;
		return ST_OK;
	endfunction

	function automatic logic [ST_W-1:0] remove_at(input int pos);
		if (list_len == 0)
			return ST_EMPTY;
		if (pos >= list_len)
			return ST_BADIDX;
		for (int i = pos; i + 1 < list_len; i++)
			list_vals[i] = list_vals[i+1];
		list_len--;
		return ST_OK;
	endfunction

	task automatic predict_list_op(input logic [OP_W-1:0] op, input logic signed [VAL_W-1:0] v,
		input logic [IDX_W-1:0] idx);
		logic [ST_W-1:0] st;
		st = ST_OK;
		if (op == OP_DUMP) begin
			if (list_len == 0) begin
				push_result(ST_EMPTY, '0, 1'b1);
			end else begin
				for (int i = 0; i < list_len; i++)
					push_result(ST_OK, list_vals[i], i + 1 == list_len);
			end
		end else begin
			case (op)
				OP_PUSH_FRONT: st = insert_at(0, v);
				OP_PUSH_BACK:  st = insert_at(list_len, v);
				OP_INSERT:     st = insert_at(int'(idx), v);
				OP_POP_FRONT:  st = remove_at(0);
				OP_POP_BACK:   st = (list_len == 0) ? ST_EMPTY : remove_at(list_len - 1);
				OP_DELETE:     st = remove_at(int'(idx));
				default:       st = ST_OK;
			endcase
			push_result(st, '0, 1'b1);
		end
	endtask

	task automatic check_result(input res_t got);
		res_t want;
		if (expected_results.size() == 0) begin
			report("arrived with nothing outstanding", longint'(got.status), -1);
		end else begin
			want = expected_results.pop_front();
			if (got.status !== want.status)
				report("status", longint'(got.status), longint'(want.status));
			if (got.elem_value !== want.elem_value)
				report("elem_value", longint'($signed(got.elem_value)),
					longint'($signed(want.elem_value)));
			if (got.count_now !== want.count_now)
				report("count_now", longint'(got.count_now), longint'(want.count_now));
			if (got.last !== want.last)
				report("last", longint'(got.last), longint'(want.last));
		end
		result_no++;
	endtask

	// response first: a result taken in the same cycle as a request belongs to an older one
	always @(posedge clk or negedge arst_n) begin
		res_t got;
		if (!arst_n) begin
			list_len = 0;
			expected_results.delete();
		end else begin
			if (rsp.valid && rsp.ready) begin
				got.status     = rsp.status;
				got.elem_value = rsp.elem_value;
				got.count_now  = rsp.count_now;
				got.last       = rsp.last;
				check_result(got);
			end
			if (req.valid && req.ready)
				predict_list_op(req.op, req.value, req.index);
		end
		pending = expected_results.size();
	end

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
	import bpl_pkg::*;

	localparam int LIST_DEPTH  = DEPTH_DEF;
	localparam int HOLD_CYCLES = 300;
	localparam int RANDOM_ITEMS = 260;

	localparam logic [OP_W-1:0]         OP_NOP  = 3'd7;
	localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;

	typedef enum int {LEAN_GROW, LEAN_SHRINK, LEAN_MIX} lean_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	bpl_in_if  req_ch ();
	bpl_out_if rsp_ch ();

	int fail_count;
	int pending;

	bit sender_idle = 1'b1;
	bit sink_idle   = 1'b1;
	bit hold_wanted = 1'b0;
	bit hold_done   = 1'b0;

	int list_guess;
	int items_sent;
	int op_tally [8];

	bounded_positional_list_unit #(
		.DEPTH (LIST_DEPTH)
	) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	bpl_checker #(
		.DEPTH (LIST_DEPTH)
	) u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req_ch),
		.rsp        (rsp_ch),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		#1_000_000;
		$display("timeout: %0d results still outstanding", pending);
		$display("tb_top NOT OK");
		$finish;
	end

	// response side: random stall bursts, and one long hold-off on request
	initial begin
		rsp_ch.ready = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_wanted && !hold_done) begin
				rsp_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done = 1'b1;
			end else if (sink_idle && $urandom_range(0, 5) == 0) begin
				rsp_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end else begin
				rsp_ch.ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	task automatic send_item(input logic [OP_W-1:0] op, input logic signed [VAL_W-1:0] val,
		input logic [IDX_W-1:0] idx);
		if (sender_idle && $urandom_range(0, 4) == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.op    <= op;
		req_ch.value <= val;
		req_ch.index <= idx;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		items_sent++;
		op_tally[op]++;
		// occupancy kept only to steer the indexes of later transactions
		case (op)
			OP_PUSH_FRONT, OP_PUSH_BACK: begin
				if (list_guess < LIST_DEPTH)
					list_guess++;
			end
			OP_INSERT: begin
				if (list_guess < LIST_DEPTH && int'(idx) <= list_guess)
					list_guess++;
			end
			OP_POP_FRONT, OP_POP_BACK: begin
				if (list_guess > 0)
					list_guess--;
			end
			OP_DELETE: begin
				if (int'(idx) < list_guess)
					list_guess--;
			end
			default: ;
		endcase
	endtask

	task automatic send_random_item(input lean_t lean);
		int                      grow_pct;
		int                      r;
		logic [OP_W-1:0]         op;
		logic signed [VAL_W-1:0] val;
		logic [IDX_W-1:0]        idx;
		case (lean)
			LEAN_GROW:   grow_pct = 65;
			LEAN_SHRINK: grow_pct = 25;
			default:     grow_pct = 45;
		endcase
		r = $urandom_range(0, 99);
		if (r < grow_pct) begin
			case ($urandom_range(0, 2))
				0:       op = OP_PUSH_FRONT;
				1:       op = OP_PUSH_BACK;
				default: op = OP_INSERT;
			endcase
		end else if (r < 88) begin
			case ($urandom_range(0, 2))
				0:       op = OP_POP_FRONT;
				1:       op = OP_POP_BACK;
				default: op = OP_DELETE;
			endcase
		end else if (r < 97) begin
			op = OP_DUMP;
		end else begin
			op = OP_NOP;
		end
		case ($urandom_range(0, 9))
			0:       val = VAL_MAX;
			1:       val = VAL_MIN;
			2:       val = '0;
			3:       val = '1;
			default: val = $urandom;
		endcase
		// mostly positions that exist, now and then anything the field holds
		if ($urandom_range(0, 6) == 0)
			idx = IDX_W'($urandom_range(0, 31));
		else
			idx = IDX_W'($urandom_range(0, list_guess));
		send_item(op, val, idx);
	endtask

	initial begin
		int    random_done;
		int    phase_len;
		lean_t lean;
		req_ch.valid = 1'b0;
		req_ch.op    = '0;
		req_ch.value = '0;
		req_ch.index = '0;
		list_guess   = 0;
		items_sent   = 0;
		random_done  = 0;
		for (int i = 0; i < 8; i++)
			op_tally[i] = 0;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty list
		send_item(OP_DUMP, '0, '0);
		send_item(OP_POP_FRONT, '0, '0);
		send_item(OP_POP_BACK, '0, '0);
		send_item(OP_DELETE, '0, 5'd0);
		// single element
		send_item(OP_PUSH_BACK, VAL_MAX, '0);
		send_item(OP_DUMP, '0, '0);
		send_item(OP_DELETE, '0, 5'd0);
		send_item(OP_PUSH_FRONT, VAL_MIN, '0);
		send_item(OP_POP_BACK, '0, '0);
		send_item(OP_INSERT, -1, 5'd0);
		// positional cases around the count
		send_item(OP_PUSH_FRONT, VAL_MIN, '1);
		send_item(OP_INSERT, '0, 5'd2);
		send_item(OP_INSERT, 32'sd5, 5'd4);
		send_item(OP_INSERT, 32'sd6, 5'd31);
		send_item(OP_INSERT, 32'sh1234_5678, 5'd1);
		send_item(OP_DELETE, '0, 5'd4);
		send_item(OP_DELETE, '0, 5'd31);
		send_item(OP_DELETE, '0, 5'd1);
		send_item(OP_NOP, '1, 5'd31);
		send_item(OP_DUMP, '0, '0);
		send_item(OP_POP_FRONT, '0, '0);
		// full list
		while (list_guess < LIST_DEPTH)
			send_item(OP_PUSH_BACK, $urandom, '0);
		send_item(OP_PUSH_FRONT, 32'sd1, '0);
		send_item(OP_INSERT, 32'sd2, 5'd31);
		send_item(OP_PUSH_BACK, 32'sd3, '0);
		send_item(OP_DUMP, '0, '0);
		send_item(OP_DELETE, '0, 5'(LIST_DEPTH - 1));

		for (int phase = 0; random_done < RANDOM_ITEMS; phase++) begin
			phase_len = $urandom_range(15, 40);
			case ($urandom_range(0, 2))
				0:       lean = LEAN_GROW;
				1:       lean = LEAN_SHRINK;
				default: lean = LEAN_MIX;
			endcase
			if (random_done >= RANDOM_ITEMS - 50) begin
				sender_idle = 1'b0;
				sink_idle   = 1'b0;
			end else begin
				sender_idle = ($urandom_range(0, 3) != 0);
				sink_idle   = ($urandom_range(0, 3) != 0);
			end
			// keep offering transactions while the response side holds off
			if (phase == 3) begin
				sender_idle = 1'b0;
				lean        = LEAN_GROW;
				hold_wanted = 1'b1;
			end
			for (int n = 0; n < phase_len && random_done < RANDOM_ITEMS; n++) begin
				send_random_item(lean);
				random_done++;
			end
		end

		req_ch.valid <= 1'b0;
		// sample away from the rising edge so the checker has seen the last transaction
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		repeat (2 * LIST_DEPTH + 8) @(posedge clk);

		$display("summary: %0d requests: %0d push/insert, %0d pop/delete, %0d dumps, %0d no-ops",
			items_sent, op_tally[OP_PUSH_FRONT] + op_tally[OP_PUSH_BACK] + op_tally[OP_INSERT],
			op_tally[OP_POP_FRONT] + op_tally[OP_POP_BACK] + op_tally[OP_DELETE],
			op_tally[OP_DUMP], op_tally[OP_NOP]);
		$display("summary: empty, single-entry and full list, bad indexes, a %0d-cycle hold-off",
			HOLD_CYCLES);
		if (fail_count == 0 && pending == 0) begin
			$display("tb_top OK");
		end else begin
			$display("tb_top NOT OK");
		end
		$finish;
	end

endmodule
